// ===== design/pls_pkg.sv =====
// shared types, operation codes and cell commands of the positional list store
package pls_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int OUT_CNT_W = 5;
    localparam int CAP_DEF   = 16;
    localparam int CAP_MAX   = 64;
    localparam int CNT_W     = $clog2(CAP_MAX + 1);

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_cnt;

    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
    localparam logic [OP_W-1:0] OP_SHOW    = 3'd4;

    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MIRROR = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SHIFT  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        t_cnt             pos;
        t_cnt             cnt;
    } t_ctl;

endpackage

// ===== design/pls_cell.sv =====
// one storage cell of the list chain
module pls_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  pls_pkg::t_ctl i_ctl,
    input  pls_pkg::t_word i_value,
    input  pls_pkg::t_word i_left,
    input  pls_pkg::t_word i_right,
    input  pls_pkg::t_word i_mirror,
    input  pls_pkg::t_word i_head,
    output pls_pkg::t_word o_data,
    output pls_pkg::t_word o_tap
);

    localparam pls_pkg::t_cnt IDX_C  = pls_pkg::t_cnt'(IDX);
    localparam pls_pkg::t_cnt IDX1_C = pls_pkg::t_cnt'(IDX + 1);

    pls_pkg::t_word r_data;
    pls_pkg::t_word n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.cmd)
            pls_pkg::CMD_APPEND: begin
                if (IDX_C == i_ctl.cnt) n_data = i_value;
            end
            pls_pkg::CMD_INSERT: begin
                if (IDX1_C == i_ctl.pos) begin
                    n_data = i_value;
                end else if (IDX1_C > i_ctl.pos && IDX_C <= i_ctl.cnt) begin
                    n_data = i_left;
                end
            end
            pls_pkg::CMD_DELETE: begin
                if (IDX1_C >= i_ctl.pos && IDX1_C < i_ctl.cnt) n_data = i_right;
            end
            pls_pkg::CMD_MIRROR: begin
                n_data = i_mirror;
            end
            pls_pkg::CMD_SHIFT: begin
                n_data = i_right;
            end
            pls_pkg::CMD_ROTATE: begin
                if (IDX1_C < i_ctl.cnt) begin
                    n_data = i_right;
                end else if (IDX1_C == i_ctl.cnt) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (IDX1_C == i_ctl.pos) ? r_data : '0;

endmodule

// ===== design/positional_list_store.sv =====
// positional list store: a chain of value cells with append, insert, delete, reverse, show
//
//  port group   direction  handshake               payload
//  command      in         start high, busy low    i_op, i_value, i_position
//  result       out        o_strobe, one cycle     o_ok, o_data, o_last, o_count_now,
//                                                  o_is_empty, o_is_full
//
// append, insert, delete and every failed command: the result shows in the cycle after
// the command is taken and the next command may be taken in that same cycle.
// reverse: the chain is mirrored on acceptance, then shifted down one cell per cycle, busy
// high, until the list starts at cell 0; the result shows in the cycle after acceptance.
// show: the block enters its show state, then gives one result per cycle, one per word,
// while the chain rotates once around; busy stays high until the last word is out.
// reset (i_rst_n low, synchronous) empties the list and drops any result in flight.
// results cannot be stalled.
module positional_list_store #(
    parameter int CAPACITY = pls_pkg::CAP_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pls_pkg::OP_W-1:0]        i_op,
    input  logic signed [pls_pkg::DATA_W-1:0] i_value,
    input  logic [pls_pkg::POS_W-1:0]       i_position,
    output logic                            o_strobe,
    output logic                            o_ok,
    output logic signed [pls_pkg::DATA_W-1:0] o_data,
    output logic                            o_last,
    output logic [pls_pkg::OUT_CNT_W-1:0]   o_count_now,
    output logic                            o_is_empty,
    output logic                            o_is_full
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHOW  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    localparam pls_pkg::t_cnt CAP_C = pls_pkg::t_cnt'(CAPACITY);
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ctr, n_ctr;

    logic                                r_strobe, n_strobe;
    logic                                r_ok, n_ok;
    pls_pkg::t_word                      r_data, n_data;
    logic                                r_last, n_last;
    logic [pls_pkg::OUT_CNT_W-1:0]       r_count_now;
    logic                                r_is_empty;
    logic                                r_is_full;

    pls_pkg::t_ctl  w_ctl;
    pls_pkg::t_word w_cell [CAPACITY];
    pls_pkg::t_word w_tap  [CAPACITY];
    pls_pkg::t_word w_tap_or;
    pls_pkg::t_cnt  w_cnt_ext;
    pls_pkg::t_cnt  w_pos_ext;
    pls_pkg::t_cnt  w_new_ext;
    logic           w_accept;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            pls_pkg::t_word w_left;
            pls_pkg::t_word w_right;
            if (g == 0) begin : g_first
                assign w_left = w_cell[g];
            end else begin : g_inner_l
                assign w_left = w_cell[g-1];
            end
            if (g == CAPACITY - 1) begin : g_end
                assign w_right = w_cell[g];
            end else begin : g_inner_r
                assign w_right = w_cell[g+1];
            end
            pls_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_value (i_value),
                .i_left  (w_left),
                .i_right (w_right),
                .i_mirror(w_cell[CAPACITY-1-g]),
                .i_head  (w_cell[0]),
                .o_data  (w_cell[g]),
                .o_tap   (w_tap[g])
            );
        end
    endgenerate

    always_comb begin
        w_tap_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_tap_or = w_tap_or | w_tap[k];
        end
    end

    assign w_cnt_ext = pls_pkg::t_cnt'(r_count);
    assign w_pos_ext = pls_pkg::t_cnt'(i_position);
    assign w_accept  = start && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ctr     = r_ctr;
        n_strobe  = 1'b0;
        n_ok      = 1'b0;
        n_data    = '0;
        n_last    = 1'b1;
        w_ctl.cmd = pls_pkg::CMD_NONE;
        w_ctl.pos = w_pos_ext;
        w_ctl.cnt = w_cnt_ext;
        unique case (r_state)
            S_SHOW: begin
                w_ctl.cmd = pls_pkg::CMD_ROTATE;
                n_strobe  = 1'b1;
                n_ok      = 1'b1;
                n_data    = w_cell[0];
                n_last    = (r_ctr == r_count - 1'b1);
                n_ctr     = r_ctr + 1'b1;
                if (n_last) n_state = S_IDLE;
            end
            S_SHIFT: begin
                w_ctl.cmd = pls_pkg::CMD_SHIFT;
                n_ctr     = r_ctr - 1'b1;
                if (r_ctr == CW'(1)) n_state = S_IDLE;
            end
            default: begin
                if (w_accept) begin
                    n_strobe = 1'b1;
                    unique case (i_op)
                        pls_pkg::OP_APPEND: begin
                            if (w_cnt_ext < CAP_C) begin
                                w_ctl.cmd = pls_pkg::CMD_APPEND;
                                n_ok      = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        pls_pkg::OP_INSERT: begin
                            if (w_pos_ext != '0 && w_pos_ext <= w_cnt_ext + 1'b1
                                && w_cnt_ext < CAP_C) begin
                                w_ctl.cmd = pls_pkg::CMD_INSERT;
                                n_ok      = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        pls_pkg::OP_DELETE: begin
                            if (w_pos_ext != '0 && w_pos_ext <= w_cnt_ext) begin
                                w_ctl.cmd = pls_pkg::CMD_DELETE;
                                n_ok      = 1'b1;
                                n_data    = w_tap_or;
                                n_count   = r_count - 1'b1;
                            end
                        end
                        pls_pkg::OP_REVERSE: begin
                            if (r_count != '0) begin
                                w_ctl.cmd = pls_pkg::CMD_MIRROR;
                                n_ok      = 1'b1;
                                if (r_count != CAP_W) begin
                                    n_state = S_SHIFT;
                                    n_ctr   = CAP_W - r_count;
                                end
                            end
                        end
                        pls_pkg::OP_SHOW: begin
                            if (r_count != '0) begin
                                n_strobe = 1'b0;
                                n_state  = S_SHOW;
                                n_ctr    = '0;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
        endcase
    end

    assign w_new_ext = pls_pkg::t_cnt'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ctr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ctr    <= n_ctr;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok        <= n_ok;
        r_data      <= n_data;
        r_last      <= n_last;
        r_count_now <= w_new_ext[pls_pkg::OUT_CNT_W-1:0];
        r_is_empty  <= (n_count == '0);
        r_is_full   <= (n_count == CAP_W);
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_ok        = r_ok;
    assign o_data      = r_data;
    assign o_last      = r_last;
    assign o_count_now = r_count_now;
    assign o_is_empty  = r_is_empty;
    assign o_is_full   = r_is_full;

endmodule

// ===== design/pls_checker.sv =====
// port-level checks of the positional list store and their binding
module pls_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [pls_pkg::OP_W-1:0]        i_op,
    input logic                            o_strobe,
    input logic                            o_ok,
    input logic                            o_last,
    input logic [pls_pkg::OUT_CNT_W-1:0]   o_count_now,
    input logic                            o_is_empty
);

    // a failed word always closes its command
    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_ok |-> o_last)
        else $error("failed result without last");

    // commands other than show answer in the next cycle
    a_single_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op != pls_pkg::OP_SHOW |=> o_strobe && o_last)
        else $error("missing result after command");

    // show either fails at once or keeps the block busy
    a_show_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op == pls_pkg::OP_SHOW |=> (o_strobe && !o_ok) || busy)
        else $error("show neither answered nor started");

    // more words of a show still to come
    a_show_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy && o_ok && !o_is_empty)
        else $error("partial show without busy");

    // empty flag tracks the count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_is_empty == (o_count_now == '0))
        else $error("empty flag mismatch");

endmodule

bind positional_list_store pls_checker u_pls_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_op       (i_op),
    .o_strobe   (o_strobe),
    .o_ok       (o_ok),
    .o_last     (o_last),
    .o_count_now(o_count_now),
    .o_is_empty (o_is_empty)
);

// ===== bench/positional_list_store_tb.sv =====
// testbench of the positional list store: directed table, then random words vs a shadow list
module positional_list_store_tb;

    localparam int CAP         = pls_pkg::CAP_DEF;
    localparam int PHASE_WORDS = 60;
    localparam int SETTLE      = 40;
    localparam int LIMIT       = 200000;

    localparam logic [pls_pkg::OP_W-1:0] OP_SPARE_0 = pls_pkg::OP_SHOW + 3'd1;
    localparam logic [pls_pkg::OP_W-1:0] OP_SPARE_1 = pls_pkg::OP_SHOW + 3'd2;
    localparam logic [pls_pkg::OP_W-1:0] OP_SPARE_2 = pls_pkg::OP_SHOW + 3'd3;

    typedef struct {
        logic                          ok;
        pls_pkg::t_word                data;
        logic                          last;
        logic [pls_pkg::OUT_CNT_W-1:0] count_now;
        logic                          is_empty;
        logic                          is_full;
    } t_list_reply;

    typedef struct {
        logic [pls_pkg::OP_W-1:0]  op;
        pls_pkg::t_word            value;
        logic [pls_pkg::POS_W-1:0] pos;
        int                        reps;
        bit                        pinned;
        bit                        ok;
        int                        cnt;
    } t_plan_row;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          start      = 1'b0;
    logic [pls_pkg::OP_W-1:0]      i_op       = pls_pkg::OP_APPEND;
    pls_pkg::t_word                i_value    = '0;
    logic [pls_pkg::POS_W-1:0]     i_position = '0;
    logic                          busy;
    logic                          o_strobe;
    logic                          o_ok;
    pls_pkg::t_word                o_data;
    logic                          o_last;
    logic [pls_pkg::OUT_CNT_W-1:0] o_count_now;
    logic                          o_is_empty;
    logic                          o_is_full;

    pls_pkg::t_word shadow_list [CAP];
    int             shadow_count = 0;
    t_list_reply    pending_replies [$];
    t_plan_row      directed_plan [$];
    int             idle_pct [4] = '{0, 59, 0, 18};
    int             mismatches = 0;
    int             cycles = 0;

    positional_list_store #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_position (i_position),
        .o_strobe   (o_strobe),
        .o_ok       (o_ok),
        .o_data     (o_data),
        .o_last     (o_last),
        .o_count_now(o_count_now),
        .o_is_empty (o_is_empty),
        .o_is_full  (o_is_full)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void queue_reply(input logic ok, input pls_pkg::t_word data,
                                        input logic last);
        t_list_reply r;
        r.ok        = ok;
        r.data      = data;
        r.last      = last;
        r.count_now = pls_pkg::OUT_CNT_W'(shadow_count);
        r.is_empty  = (shadow_count == 0);
        r.is_full   = (shadow_count == CAP);
        pending_replies.push_back(r);
    endfunction

    function automatic void list_apply(input logic [pls_pkg::OP_W-1:0] op,
                                       input pls_pkg::t_word value,
                                       input logic [pls_pkg::POS_W-1:0] pos);
        int             n;
        int             p;
        int             a;
        int             b;
        pls_pkg::t_word held;
        n = shadow_count;
        p = int'(pos);
        case (op)
            pls_pkg::OP_APPEND: begin
                if (n >= CAP) begin
                    queue_reply(1'b0, '0, 1'b1);
                end else begin
                    shadow_list[n] = value;
                    shadow_count   = n + 1;
                    queue_reply(1'b1, '0, 1'b1);
                end
            end
            pls_pkg::OP_INSERT: begin
                if (p < 1 || p > n + 1 || n >= CAP) begin
                    queue_reply(1'b0, '0, 1'b1);
                end else begin
                    for (int i = n; i >= p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p-1] = value;
                    shadow_count     = n + 1;
                    queue_reply(1'b1, '0, 1'b1);
                end
            end
            pls_pkg::OP_DELETE: begin
                if (p < 1 || p > n) begin
                    queue_reply(1'b0, '0, 1'b1);
                end else begin
                    held = shadow_list[p-1];
                    for (int i = p; i < n; i++)
                        shadow_list[i-1] = shadow_list[i];
                    shadow_count = n - 1;
                    queue_reply(1'b1, held, 1'b1);
                end
            end
            pls_pkg::OP_REVERSE: begin
                if (n == 0) begin
                    queue_reply(1'b0, '0, 1'b1);
                end else begin
                    a = 0;
                    b = n - 1;
                    while (a < b) begin
                        held           = shadow_list[a];
                        shadow_list[a] = shadow_list[b];
                        shadow_list[b] = held;
                        a++;
                        b--;
                    end
                    queue_reply(1'b1, '0, 1'b1);
                end
            end
            pls_pkg::OP_SHOW: begin
                if (n == 0) begin
                    queue_reply(1'b0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        queue_reply(1'b1, shadow_list[i], i + 1 == n);
                end
            end
            default: begin
                queue_reply(1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    task automatic compare(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // a pinned word replaces the prediction with the value typed in the table
    task automatic send_word(input logic [pls_pkg::OP_W-1:0] op, input pls_pkg::t_word value,
                             input logic [pls_pkg::POS_W-1:0] pos, input bit pinned,
                             input bit pin_ok, input int pin_cnt);
        t_list_reply fixed;
        start      <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        i_position <= pos;
        do @(posedge i_clk); while (busy);
        list_apply(op, value, pos);
        if (pinned) begin
            fixed.ok        = pin_ok;
            fixed.data      = '0;
            fixed.last      = 1'b1;
            fixed.count_now = pls_pkg::OUT_CNT_W'(pin_cnt);
            fixed.is_empty  = (pin_cnt == 0);
            fixed.is_full   = (pin_cnt == CAP);
            pending_replies[$] = fixed;
        end
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic plan(input logic [pls_pkg::OP_W-1:0] op, input pls_pkg::t_word value,
                        input logic [pls_pkg::POS_W-1:0] pos, input int reps, input bit pinned,
                        input bit ok, input int cnt);
        t_plan_row row;
        row.op     = op;
        row.value  = value;
        row.pos    = pos;
        row.reps   = reps;
        row.pinned = pinned;
        row.ok     = ok;
        row.cnt    = cnt;
        directed_plan.push_back(row);
    endtask

    always @(posedge i_clk) begin : watch
        t_list_reply want;
        if (i_rst_n && o_strobe) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: word expected none, got data %0d ok %0d", $time, o_data, o_ok);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                compare("ok", want.ok, o_ok);
                compare("data", want.data, o_data);
                compare("last", want.last, o_last);
                compare("count_now", want.count_now, o_count_now);
                compare("is_empty", want.is_empty, o_is_empty);
                compare("is_full", want.is_full, o_is_full);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [pls_pkg::OP_W-1:0]  op;
        pls_pkg::t_word            value;
        logic [pls_pkg::POS_W-1:0] pos;
        int                        n;
        int                        r;

        //   op                   value            pos   reps pin ok cnt
        plan(pls_pkg::OP_SHOW,    '0,              5'd0,  1,  1, 0, 0);
        plan(pls_pkg::OP_REVERSE, '0,              5'd0,  1,  1, 0, 0);
        plan(pls_pkg::OP_DELETE,  '0,              5'd1,  1,  1, 0, 0);
        plan(pls_pkg::OP_INSERT,  '0,              5'd0,  1,  1, 0, 0);
        plan(pls_pkg::OP_INSERT,  32'sd7,          5'd2,  1,  1, 0, 0);
        plan(pls_pkg::OP_INSERT,  32'sh8000_0000,  5'd1,  1,  1, 1, 1);
        plan(pls_pkg::OP_APPEND,  32'sh7FFF_FFFF,  5'd0,  1,  1, 1, 2);
        plan(pls_pkg::OP_INSERT,  -32'sd1,         5'd3,  1,  1, 1, 3);
        plan(pls_pkg::OP_INSERT,  32'sh5555_5555,  5'd2,  1,  0, 0, 0);
        plan(pls_pkg::OP_SHOW,    '0,              5'd0,  1,  0, 0, 0);
        plan(pls_pkg::OP_REVERSE, '0,              5'd0,  1,  0, 0, 0);
        plan(pls_pkg::OP_SHOW,    '0,              5'd0,  1,  0, 0, 0);
        plan(pls_pkg::OP_DELETE,  '0,              5'd5,  1,  1, 0, 4);
        plan(pls_pkg::OP_DELETE,  '0,              5'd31, 1,  1, 0, 4);
        plan(pls_pkg::OP_DELETE,  '0,              5'd1,  1,  0, 0, 0);
        plan(OP_SPARE_0,          32'sd1,          5'd1,  1,  1, 0, 3);
        plan(OP_SPARE_1,          32'sd1,          5'd1,  1,  1, 0, 3);
        plan(OP_SPARE_2,          -32'sd1,         5'd31, 1,  1, 0, 3);
        plan(pls_pkg::OP_APPEND,  32'shA5A5_0F0F,  5'd0,  13, 0, 0, 0);
        plan(pls_pkg::OP_APPEND,  32'sd9,          5'd0,  1,  1, 0, 16);
        plan(pls_pkg::OP_INSERT,  32'sd9,          5'd1,  1,  1, 0, 16);
        plan(pls_pkg::OP_INSERT,  32'sd9,          5'd17, 1,  1, 0, 16);
        plan(pls_pkg::OP_SHOW,    '0,              5'd0,  1,  0, 0, 0);
        plan(pls_pkg::OP_DELETE,  '0,              5'd16, 1,  0, 0, 0);
        plan(pls_pkg::OP_REVERSE, '0,              5'd0,  1,  0, 0, 0);
        plan(pls_pkg::OP_SHOW,    '0,              5'd0,  1,  0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k])
            repeat (directed_plan[k].reps)
                send_word(directed_plan[k].op, directed_plan[k].value, directed_plan[k].pos,
                          directed_plan[k].pinned, directed_plan[k].ok, directed_plan[k].cnt);
        settle();

        foreach (idle_pct[ph]) begin
            for (int k = 0; k < PHASE_WORDS; k++) begin
                n = shadow_count;
                r = $urandom_range(0, 99);
                if (r < 4)
                    op = pls_pkg::OP_SHOW + pls_pkg::OP_W'($urandom_range(1, 3));
                else if (r < 30)
                    op = pls_pkg::OP_APPEND;
                else if (r < 52)
                    op = pls_pkg::OP_INSERT;
                else if (r < 76)
                    op = pls_pkg::OP_DELETE;
                else if (r < 88)
                    op = pls_pkg::OP_REVERSE;
                else
                    op = pls_pkg::OP_SHOW;
                // keep the list moving between nearly empty and nearly full
                if (n >= CAP - 2 && (op == pls_pkg::OP_APPEND || op == pls_pkg::OP_INSERT)
                    && $urandom_range(0, 1))
                    op = pls_pkg::OP_DELETE;
                if (n <= 2 && op == pls_pkg::OP_DELETE && $urandom_range(0, 1))
                    op = pls_pkg::OP_APPEND;
                if ($urandom_range(0, 99) < 85)
                    pos = (op == pls_pkg::OP_DELETE)
                        ? pls_pkg::POS_W'($urandom_range(1, (n > 0) ? n : 1))
                        : pls_pkg::POS_W'($urandom_range(1, n + 1));
                else
                    pos = pls_pkg::POS_W'($urandom_range(0, 31));
                case ($urandom_range(0, 9))
                    0:       value = 32'sh8000_0000;
                    1:       value = 32'sh7FFF_FFFF;
                    2:       value = -32'sd1;
                    3:       value = '0;
                    default: value = $urandom();
                endcase
                if ($urandom_range(0, 99) < idle_pct[ph])
                    hold_off(($urandom_range(0, 15) == 0) ? $urandom_range(5, 24)
                                                          : $urandom_range(1, 3));
                send_word(op, value, pos, 1'b0, 1'b0, 0);
            end
            settle();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pls_pkg.sv
design/pls_cell.sv
design/positional_list_store.sv
design/pls_checker.sv
bench/positional_list_store_tb.sv
